// File: hdl/sdfbic_pkg.sv
// Shared constants, codes and command types of the SDF block importance classifier.
package sdfbic_pkg;

  localparam int SAMPLE_WIDTH_DEF = 32;

  localparam int EXT_W      = 31;
  localparam int BAND_W     = 31;
  localparam int FACT_W     = 16;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // band * clamped factor fits in 46 bits, its square in 92
  localparam int P_W       = BAND_W + FACT_W - 1;
  localparam int Q_W       = 2 * P_W;
  localparam int S_W       = 64;
  localparam int MUL_B_W   = S_W;
  localparam int CNT_W     = $clog2(MUL_B_W);
  localparam int LHS_SHIFT = 48;
  localparam int PROD_W    = Q_W + S_W;

  localparam logic [S_W-1:0] S2_FLOOR = S_W'(64'h1_0000_0000);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_BAND    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_FACTOR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_BAND   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_FACTOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_DIAG     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_SIGN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_MIN      = 3'd6;

  localparam logic [1:0] IMP_NEAR  = 2'd0;
  localparam logic [1:0] IMP_TRANS = 2'd1;
  localparam logic [1:0] IMP_FAR   = 2'd2;

  localparam logic [1:0] WARN_NONE      = 2'd0;
  localparam logic [1:0] WARN_EMPTY     = 2'd1;
  localparam logic [1:0] WARN_NONFINITE = 2'd2;

  // multiplier operand selects
  typedef logic [2:0] mul_src_t;
  localparam mul_src_t SRC_EX = 3'd0;
  localparam mul_src_t SRC_EY = 3'd1;
  localparam mul_src_t SRC_EZ = 3'd2;
  localparam mul_src_t SRC_MM = 3'd3;
  localparam mul_src_t SRC_PN = 3'd4;
  localparam mul_src_t SRC_PT = 3'd5;
  localparam mul_src_t SRC_PP = 3'd6;
  localparam mul_src_t SRC_QS = 3'd7;

  // where a finished product goes
  typedef logic [2:0] store_dst_t;
  localparam store_dst_t DST_NONE  = 3'd0;
  localparam store_dst_t DST_S     = 3'd1;
  localparam store_dst_t DST_LHS   = 3'd2;
  localparam store_dst_t DST_P     = 3'd3;
  localparam store_dst_t DST_Q     = 3'd4;
  localparam store_dst_t DST_NEAR  = 3'd5;
  localparam store_dst_t DST_TRANS = 3'd6;

  typedef struct packed {
    logic       take;
    logic       take_end;
    logic       load;
    logic       clr;
    logic       step;
    mul_src_t   src;
    logic       store;
    store_dst_t dst;
    logic       finish;
  } dp_cmd_t;

endpackage

// File: hdl/sdf_block_importance_classifier.sv
// Top level of the SDF block importance classifier.
// Samples of a block arrive one per beat and are taken at one per cycle while
// the block is collecting; the beat flagged block_end closes the block. The
// classification then runs on one shared shift-add multiplier, one multiplier
// bit per cycle, through ten products (three extent squares, the squared
// minimum, and band*factor, its square and that times the squared diagonal for
// each band), so the input stalls after the end beat until the result is issued,
// including any wait for the previous result to leave the output register.
// Results sit in an output register, so collection of the next block proceeds
// while a result is still stalled. Configuration is always ready and is to be
// written only while no block is in flight.
module sdf_block_importance_classifier import sdfbic_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_distance,
  input  logic                           in_not_finite,
  input  logic                           in_sample_present,
  input  logic                           in_block_end,
  input  logic                           in_bounds_valid,
  input  logic [EXT_W-1:0]               in_extent_x,
  input  logic [EXT_W-1:0]               in_extent_y,
  input  logic [EXT_W-1:0]               in_extent_z,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_importance,
  output logic [OUT_W-1:0]               out_min_abs_distance,
  output logic [OUT_W-1:0]               out_max_abs_distance,
  output logic                           out_sign_change,
  output logic [1:0]                     out_warning,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data
);

  dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  sdfbic_ctrl #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_block_end(in_block_end),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd)
  );

  sdfbic_dp #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_distance         (in_distance),
    .in_not_finite       (in_not_finite),
    .in_sample_present   (in_sample_present),
    .in_bounds_valid     (in_bounds_valid),
    .in_extent_x         (in_extent_x),
    .in_extent_y         (in_extent_y),
    .in_extent_z         (in_extent_z),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_importance      (out_importance),
    .out_min_abs_distance(out_min_abs_distance),
    .out_max_abs_distance(out_max_abs_distance),
    .out_sign_change     (out_sign_change),
    .out_warning         (out_warning)
  );

endmodule

// File: hdl/sdfbic_dp.sv
// Datapath: config registers, block statistics, shift-add multiplier and result register.
module sdfbic_dp import sdfbic_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dp_cmd_t                        cmd,
  input  logic signed [SAMPLE_WIDTH-1:0] in_distance,
  input  logic                           in_not_finite,
  input  logic                           in_sample_present,
  input  logic                           in_bounds_valid,
  input  logic [EXT_W-1:0]               in_extent_x,
  input  logic [EXT_W-1:0]               in_extent_y,
  input  logic [EXT_W-1:0]               in_extent_z,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  output logic [1:0]                     out_importance,
  output logic [OUT_W-1:0]               out_min_abs_distance,
  output logic [OUT_W-1:0]               out_max_abs_distance,
  output logic                           out_sign_change,
  output logic [1:0]                     out_warning
);

  localparam int W      = SAMPLE_WIDTH;
  localparam int LHS_W  = 2 * W;
  localparam int ACC_W  = (PROD_W > LHS_W + LHS_SHIFT) ? PROD_W : LHS_W + LHS_SHIFT;
  localparam int XW     = (W > OUT_W) ? W : OUT_W;

  // configuration
  logic [BAND_W-1:0]        near_band_r, trans_band_r;
  logic signed [FACT_W-1:0] near_factor_r, trans_factor_r;
  logic                     use_diag_r, use_sign_r, use_min_r;

  // block statistics
  logic [W-1:0] min_r, max_r;
  logic         pos_r, neg_r, bad_r, any_r;

  // captured at the end beat
  logic [EXT_W-1:0] ext_x_r, ext_y_r, ext_z_r;
  logic             bv_r;

  // multiplier and intermediates
  logic [ACC_W-1:0]   a_r, acc_r;
  logic [MUL_B_W-1:0] b_r;
  logic [S_W-1:0]     s2_r;
  logic [LHS_W-1:0]   lhs_r;
  logic [P_W-1:0]     p_r;
  logic [Q_W-1:0]     q_r;
  logic               near_ok_r, trans_ok_r;

  logic [W-1:0]       raw, abs_val;
  logic               raw_neg;
  logic [ACC_W-1:0]   a_sel, lhs_sh;
  logic [MUL_B_W-1:0] b_sel;
  logic [FACT_W-1:0]  near_f, trans_f;
  logic [S_W-1:0]     s_sum;
  logic               sc;
  logic [1:0]         imp;
  logic [XW-1:0]      min_x, max_x;

  assign raw     = in_distance;
  assign raw_neg = raw[W-1];
  assign abs_val = raw_neg ? W'(~raw + W'(1)) : raw;

  assign near_f  = near_factor_r[FACT_W-1]  ? '0 : near_factor_r;
  assign trans_f = trans_factor_r[FACT_W-1] ? '0 : trans_factor_r;

  assign s_sum  = acc_r[S_W-1:0];
  assign lhs_sh = ACC_W'({lhs_r, {LHS_SHIFT{1'b0}}});

  always_comb begin
    case (cmd.src)
      SRC_EX: begin
        a_sel = ACC_W'(ext_x_r);
        b_sel = MUL_B_W'(ext_x_r);
      end
      SRC_EY: begin
        a_sel = ACC_W'(ext_y_r);
        b_sel = MUL_B_W'(ext_y_r);
      end
      SRC_EZ: begin
        a_sel = ACC_W'(ext_z_r);
        b_sel = MUL_B_W'(ext_z_r);
      end
      SRC_MM: begin
        a_sel = ACC_W'(min_r);
        b_sel = MUL_B_W'(min_r);
      end
      SRC_PN: begin
        a_sel = ACC_W'(near_band_r);
        b_sel = MUL_B_W'(near_f);
      end
      SRC_PT: begin
        a_sel = ACC_W'(trans_band_r);
        b_sel = MUL_B_W'(trans_f);
      end
      SRC_PP: begin
        a_sel = ACC_W'(p_r);
        b_sel = MUL_B_W'(p_r);
      end
      SRC_QS: begin
        a_sel = ACC_W'(q_r);
        b_sel = MUL_B_W'(s2_r);
      end
      default: begin
        a_sel = '0;
        b_sel = '0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_band_r    <= '0;
      near_factor_r  <= FACT_W'(256);
      trans_band_r   <= '0;
      trans_factor_r <= FACT_W'(256);
      use_diag_r     <= 1'b0;
      use_sign_r     <= 1'b1;
      use_min_r      <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NEAR_BAND:    near_band_r    <= cfg_data[BAND_W-1:0];
        CFG_NEAR_FACTOR:  near_factor_r  <= cfg_data[FACT_W-1:0];
        CFG_TRANS_BAND:   trans_band_r   <= cfg_data[BAND_W-1:0];
        CFG_TRANS_FACTOR: trans_factor_r <= cfg_data[FACT_W-1:0];
        CFG_USE_DIAG:     use_diag_r     <= cfg_data[0];
        CFG_USE_SIGN:     use_sign_r     <= cfg_data[0];
        CFG_USE_MIN:      use_min_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // per-sample statistics; cleared when the block's result is issued
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.finish) begin
      min_r <= '1;
      max_r <= '0;
      pos_r <= 1'b0;
      neg_r <= 1'b0;
      bad_r <= 1'b0;
      any_r <= 1'b0;
    end else if (cmd.take && in_sample_present && !bad_r) begin
      if (in_not_finite) begin
        bad_r <= 1'b1;
      end else begin
        if (abs_val < min_r) min_r <= abs_val;
        if (abs_val > max_r) max_r <= abs_val;
        if (raw_neg) neg_r <= 1'b1;
        else if (raw != '0) pos_r <= 1'b1;
        any_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_end) begin
      ext_x_r <= in_extent_x;
      ext_y_r <= in_extent_y;
      ext_z_r <= in_extent_z;
      bv_r    <= in_bounds_valid;
    end
  end

  // shift-add multiplier, one bit of b per cycle while cmd.step is set, accumulating into acc_r
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= a_sel;
      b_r <= b_sel;
      if (cmd.clr) acc_r <= '0;
    end else if (cmd.step) begin
      if (b_r[0]) acc_r <= acc_r + a_r;
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      case (cmd.dst)
        DST_S:     s2_r <= (use_diag_r && bv_r && s_sum > S2_FLOOR) ? s_sum : S2_FLOOR;
        DST_LHS:   lhs_r <= acc_r[LHS_W-1:0];
        DST_P:     p_r <= acc_r[P_W-1:0];
        DST_Q:     q_r <= acc_r[Q_W-1:0];
        DST_NEAR:  near_ok_r <= (lhs_sh <= acc_r);
        DST_TRANS: trans_ok_r <= (lhs_sh <= acc_r);
        default: ;
      endcase
    end
  end

  assign sc    = pos_r && neg_r;
  assign min_x = XW'(min_r);
  assign max_x = XW'(max_r);

  always_comb begin
    if ((use_sign_r && sc) || (use_min_r && near_ok_r)) imp = IMP_NEAR;
    else if (use_min_r && trans_ok_r)                   imp = IMP_TRANS;
    else                                                imp = IMP_FAR;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (bad_r) begin
        out_importance       <= IMP_NEAR;
        out_min_abs_distance <= '0;
        out_max_abs_distance <= max_x[OUT_W-1:0];
        out_sign_change      <= 1'b0;
        out_warning          <= WARN_NONFINITE;
      end else if (!any_r) begin
        out_importance       <= IMP_FAR;
        out_min_abs_distance <= '0;
        out_max_abs_distance <= '0;
        out_sign_change      <= 1'b0;
        out_warning          <= WARN_EMPTY;
      end else begin
        out_importance       <= imp;
        out_min_abs_distance <= min_x[OUT_W-1:0];
        out_max_abs_distance <= max_x[OUT_W-1:0];
        out_sign_change      <= sc;
        out_warning          <= WARN_NONE;
      end
    end
  end

endmodule

// File: hdl/sdfbic_ctrl.sv
// Controller: input/output handshake and the multiply sequence run at block end.
module sdfbic_ctrl import sdfbic_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_block_end,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_RUN    = 3'd2;
  localparam logic [2:0] ST_STORE  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  localparam int             PH_W    = 4;
  localparam logic [PH_W-1:0] PH_LAST = 4'd9;

  typedef struct packed {
    mul_src_t         src;
    logic             clr;
    logic [CNT_W-1:0] len_m1;
    store_dst_t       dst;
  } prog_t;

  // squared diagonal, squared minimum, then near and transition right-hand sides
  function automatic prog_t prog(input logic [PH_W-1:0] ph);
    prog_t p;
    p = '{src: SRC_EX, clr: 1'b1, len_m1: CNT_W'(EXT_W - 1), dst: DST_NONE};
    case (ph)
      4'd0: p = '{src: SRC_EX, clr: 1'b1, len_m1: CNT_W'(EXT_W - 1), dst: DST_NONE};
      4'd1: p = '{src: SRC_EY, clr: 1'b0, len_m1: CNT_W'(EXT_W - 1), dst: DST_NONE};
      4'd2: p = '{src: SRC_EZ, clr: 1'b0, len_m1: CNT_W'(EXT_W - 1), dst: DST_S};
      4'd3: p = '{src: SRC_MM, clr: 1'b1, len_m1: CNT_W'(SAMPLE_WIDTH - 1), dst: DST_LHS};
      4'd4: p = '{src: SRC_PN, clr: 1'b1, len_m1: CNT_W'(FACT_W - 1), dst: DST_P};
      4'd5: p = '{src: SRC_PP, clr: 1'b1, len_m1: CNT_W'(P_W - 1), dst: DST_Q};
      4'd6: p = '{src: SRC_QS, clr: 1'b1, len_m1: CNT_W'(S_W - 1), dst: DST_NEAR};
      4'd7: p = '{src: SRC_PT, clr: 1'b1, len_m1: CNT_W'(FACT_W - 1), dst: DST_P};
      4'd8: p = '{src: SRC_PP, clr: 1'b1, len_m1: CNT_W'(P_W - 1), dst: DST_Q};
      4'd9: p = '{src: SRC_QS, clr: 1'b1, len_m1: CNT_W'(S_W - 1), dst: DST_TRANS};
      default: ;
    endcase
    return p;
  endfunction

  logic [2:0]       state_r, state_nxt;
  logic [PH_W-1:0]  ph_r, ph_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  prog_t            pg;

  assign pg        = prog(ph_r);
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.src   = pg.src;
    cmd.dst   = pg.dst;
    cmd.clr   = pg.clr;
    case (state_r)
      ST_IDLE: begin
        cmd.take     = in_valid;
        cmd.take_end = in_valid && in_block_end;
        if (in_valid && in_block_end) begin
          ph_nxt    = '0;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        cnt_nxt   = pg.len_m1;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (cnt_r == '0) state_nxt = ST_STORE;
        else cnt_nxt = cnt_r - CNT_W'(1);
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (ph_r == PH_LAST) begin
          state_nxt = ST_FINISH;
        end else begin
          ph_nxt    = ph_r + PH_W'(1);
          state_nxt = ST_LOAD;
        end
      end
      ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.finish)                   out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    else                              out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
